[hw/rtl/tts_pkg.sv]
// ----------------------------------------------------------------------------
// tts_pkg
// Types and fixed constants shared by the tick task scheduler modules.
// ----------------------------------------------------------------------------
package tts_pkg;

	localparam int SLOT_BITS  = 4;
	localparam int SLOT_COUNT = 16;
	localparam int FIELD_BITS = 16;
	localparam int TIME_BITS  = 27;

	// Milliseconds in one day; the clock wraps here.
	localparam logic [TIME_BITS-1:0] DAY_MS = 27'd86400000;

	typedef enum logic [2:0] {
		MODE_TICK     = 3'd0,
		MODE_ADD      = 3'd1,
		MODE_REMOVE   = 3'd2,
		MODE_DISPATCH = 3'd3,
		MODE_SET_TIME = 3'd4
	} mode_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ADD,
		S_TICK,
		S_REM,
		S_DSP,
		S_DSP_CHK,
		S_SET,
		S_DONE
	} state_t;

	// Commands to the millisecond clock.
	typedef struct packed {
		logic inc;
		logic load;
	} clk_ctl_t;

endpackage

[hw/rtl/tick_task_scheduler_top.sv]
// ----------------------------------------------------------------------------
// tick_task_scheduler_top
// Cooperative tick scheduler over sixteen task slots kept in insertion order.
// ----------------------------------------------------------------------------
// One command is taken while busy is low and start is high; exactly one result
// beat follows, shown for a single cycle with done high, and it must be taken
// then because the block cannot hold it. A small sequencer walks the slot
// memories through one shared decrement and compare unit, one entry per cycle.
// A tick walks all sixteen slots from start to done. Add and set time pass
// through one working state; the unused modes and a remove of a slot that is
// not listed go straight to done. Remove of a listed slot walks the list once.
// Dispatch walks the list until the first ready task or the list end, and a
// one-shot task adds a remove pass on top. busy stays high until the done
// cycle has passed.
// ----------------------------------------------------------------------------
module tick_task_scheduler_top #(
	parameter int MAX_TASKS  = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	output logic                           busy,
	input  logic [2:0]                     mode,
	input  logic [tts_pkg::SLOT_BITS-1:0]  task_slot,
	input  logic [tts_pkg::FIELD_BITS-1:0] period,
	input  logic [tts_pkg::FIELD_BITS-1:0] first_delay,
	input  logic [tts_pkg::TIME_BITS-1:0]  new_time,
	output logic                           done,
	output logic                           dispatch_valid,
	output logic [tts_pkg::SLOT_BITS-1:0]  ran_slot,
	output logic                           one_shot_removed,
	output logic                           add_accepted,
	output logic [tts_pkg::TIME_BITS-1:0]  current_time
);
	import tts_pkg::*;

	localparam int LW = $clog2(MAX_TASKS + 1);
	localparam int AB = $clog2(MAX_TASKS);
	localparam int IW = (LW > SLOT_BITS + 1) ? LW : SLOT_BITS + 1;

	state_t state_q, state_d;

	// Command registers.
	logic [SLOT_BITS-1:0]  op_slot_q;
	logic [FIELD_BITS-1:0] period_q;
	logic [FIELD_BITS-1:0] delay_q;
	logic [TIME_BITS-1:0]  new_time_q;

	// Table state.
	logic [LW-1:0]         len_q;
	logic [SLOT_COUNT-1:0] listed_q;
	logic [SLOT_COUNT-1:0] ready_q;

	// Walker.
	logic [IW-1:0]        idx_q;
	logic [LW-1:0]        w_q;
	logic                 v_s1;
	logic [SLOT_BITS-1:0] tick_slot_s1;

	// Result registers.
	logic                 dvalid_q;
	logic [SLOT_BITS-1:0] dslot_q;
	logic                 once_q;
	logic                 acc_q;

	// Memories and their registered read data.
	logic [SLOT_BITS-1:0]  ord_mem [MAX_TASKS];
	logic [COUNT_BITS-1:0] cnt_mem [SLOT_COUNT];
	logic [COUNT_BITS-1:0] per_mem [SLOT_COUNT];
	logic [SLOT_BITS-1:0]  ord_rd_q;
	logic [COUNT_BITS-1:0] cnt_rd_q;
	logic [COUNT_BITS-1:0] per_rd_q;

	// Control decode.
	logic                  accept;
	logic [IW-1:0]         limit;
	logic                  issue;
	logic                  scan_end;
	logic                  hit;
	logic                  tick_wr;
	logic                  tick_fin;
	logic                  rem_keep;
	logic                  rem_fin;
	logic                  dsp_miss;
	logic                  one_shot;
	logic                  add_ok;
	logic [SLOT_BITS-1:0]  per_raddr;
	logic [COUNT_BITS-1:0] cnt_dec;
	logic                  cnt_zero;
	logic                  ord_we;
	logic [AB-1:0]         ord_waddr;
	logic [SLOT_BITS-1:0]  ord_wdata;
	logic                  cnt_we;
	logic [SLOT_BITS-1:0]  cnt_waddr;
	logic [COUNT_BITS-1:0] cnt_wdata;
	clk_ctl_t              clk_ctl;

	assign accept = start && !busy;

	// Shared countdown unit: decrement if nonzero, reload on reaching zero.
	assign cnt_dec  = (cnt_rd_q != '0) ? cnt_rd_q - 1'b1 : cnt_rd_q;
	assign cnt_zero = (cnt_dec == '0);

	always_comb begin
		limit     = (state_q == S_TICK) ? IW'(SLOT_COUNT) : IW'(len_q);
		scan_end  = (idx_q == limit) && !v_s1;
		hit       = (state_q == S_DSP) && v_s1 && ready_q[ord_rd_q];
		issue     = ((state_q == S_TICK) || (state_q == S_REM) ||
			((state_q == S_DSP) && !hit)) && (idx_q < limit);
		tick_wr   = (state_q == S_TICK) && v_s1 && listed_q[tick_slot_s1];
		tick_fin  = (state_q == S_TICK) && scan_end;
		rem_keep  = (state_q == S_REM) && v_s1 && (ord_rd_q != op_slot_q);
		rem_fin   = (state_q == S_REM) && scan_end;
		dsp_miss  = (state_q == S_DSP) && scan_end;
		one_shot  = (state_q == S_DSP_CHK) && (per_rd_q == '0);
		add_ok    = (state_q == S_ADD) && !listed_q[op_slot_q] &&
			(len_q < LW'(MAX_TASKS));
		per_raddr = (state_q == S_TICK) ? idx_q[SLOT_BITS-1:0] : ord_rd_q;

		ord_we    = add_ok || rem_keep;
		ord_waddr = add_ok ? len_q[AB-1:0] : w_q[AB-1:0];
		ord_wdata = add_ok ? op_slot_q : ord_rd_q;
		cnt_we    = add_ok || tick_wr;
		cnt_waddr = add_ok ? op_slot_q : tick_slot_s1;
		cnt_wdata = add_ok ? COUNT_BITS'(delay_q) : (cnt_zero ? per_rd_q : cnt_dec);

		clk_ctl.inc  = tick_fin;
		clk_ctl.load = (state_q == S_SET);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (mode_t'(mode))
						MODE_TICK:     state_d = S_TICK;
						MODE_ADD:      state_d = S_ADD;
						MODE_REMOVE:   state_d = listed_q[task_slot] ? S_REM : S_DONE;
						MODE_DISPATCH: state_d = S_DSP;
						MODE_SET_TIME: state_d = S_SET;
						default:       state_d = S_DONE;
					endcase
				end
			end
			S_ADD:     state_d = S_DONE;
			S_TICK:    if (tick_fin) state_d = S_DONE;
			S_REM:     if (rem_fin) state_d = S_DONE;
			S_DSP: begin
				if (hit) state_d = S_DSP_CHK;
				else if (dsp_miss) state_d = S_DONE;
			end
			S_DSP_CHK: state_d = one_shot ? S_REM : S_DONE;
			S_SET:     state_d = S_DONE;
			S_DONE:    state_d = S_IDLE;
			default:   state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			len_q        <= '0;
			listed_q     <= '0;
			ready_q      <= '0;
			idx_q        <= '0;
			w_q          <= '0;
			v_s1         <= 1'b0;
			tick_slot_s1 <= '0;
			op_slot_q    <= '0;
			period_q     <= '0;
			delay_q      <= '0;
			new_time_q   <= '0;
			dvalid_q     <= 1'b0;
			dslot_q      <= '0;
			once_q       <= 1'b0;
			acc_q        <= 1'b0;
		end else begin
			state_q      <= state_d;
			v_s1         <= issue;
			tick_slot_s1 <= idx_q[SLOT_BITS-1:0];
			if (issue) begin
				idx_q <= idx_q + 1'b1;
			end
			if (accept) begin
				op_slot_q  <= task_slot;
				period_q   <= period;
				delay_q    <= first_delay;
				new_time_q <= new_time;
				idx_q      <= '0;
				w_q        <= '0;
				dvalid_q   <= 1'b0;
				dslot_q    <= '0;
				once_q     <= 1'b0;
				acc_q      <= 1'b0;
			end
			if (tick_wr && cnt_zero) begin
				ready_q[tick_slot_s1] <= 1'b1;
			end
			if (rem_keep) begin
				w_q <= w_q + 1'b1;
			end
			if (hit) begin
				ready_q[ord_rd_q] <= 1'b0;
				dvalid_q          <= 1'b1;
				dslot_q           <= ord_rd_q;
			end
			// A one-shot task goes through the same unlink pass as remove.
			if (one_shot) begin
				once_q    <= 1'b1;
				op_slot_q <= dslot_q;
				idx_q     <= '0;
				w_q       <= '0;
			end
			if (add_ok) begin
				listed_q[op_slot_q] <= 1'b1;
				ready_q[op_slot_q]  <= 1'b0;
				len_q               <= len_q + 1'b1;
				acc_q               <= 1'b1;
			end
			if (rem_fin) begin
				len_q               <= w_q;
				listed_q[op_slot_q] <= 1'b0;
				ready_q[op_slot_q]  <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		ord_rd_q <= ord_mem[idx_q[AB-1:0]];
		cnt_rd_q <= cnt_mem[idx_q[SLOT_BITS-1:0]];
		per_rd_q <= per_mem[per_raddr];
		if (ord_we) begin
			ord_mem[ord_waddr] <= ord_wdata;
		end
		if (cnt_we) begin
			cnt_mem[cnt_waddr] <= cnt_wdata;
		end
		if (add_ok) begin
			per_mem[op_slot_q] <= COUNT_BITS'(period_q);
		end
	end

	tts_clock u_clock (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (clk_ctl),
		.new_time (new_time_q),
		.time_ms  (current_time)
	);

	assign busy             = (state_q != S_IDLE);
	assign done             = (state_q == S_DONE);
	assign dispatch_valid   = dvalid_q;
	assign ran_slot         = dslot_q;
	assign one_shot_removed = once_q;
	assign add_accepted     = acc_q;

	a_done_then_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !busy)
		else $error("block stayed busy after the result beat");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy)
		else $error("accepted command did not start work");

	a_len_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> ($countones(listed_q) == len_q))
		else $error("list length disagrees with listed slots");

	a_len_bound: assert property (@(posedge clk) disable iff (!arst_n)
		len_q <= LW'(MAX_TASKS))
		else $error("list length past capacity");

	a_one_shot_gone: assert property (@(posedge clk) disable iff (!arst_n)
		(done && one_shot_removed) |-> (dispatch_valid && !listed_q[ran_slot]))
		else $error("one-shot task still listed after dispatch");

endmodule

[hw/rtl/tts_clock.sv]
// ----------------------------------------------------------------------------
// tts_clock
// Millisecond time of day: advances by one per tick, wraps at one day, and
// loads a new value reduced into the day range.
// ----------------------------------------------------------------------------
module tts_clock (
	input  logic                          clk,
	input  logic                          arst_n,
	input  tts_pkg::clk_ctl_t             ctl,
	input  logic [tts_pkg::TIME_BITS-1:0] new_time,
	output logic [tts_pkg::TIME_BITS-1:0] time_ms
);
	import tts_pkg::*;

	logic [TIME_BITS-1:0] time_q;
	logic [TIME_BITS-1:0] inc_val;
	logic [TIME_BITS-1:0] load_val;

	// The input field is below twice a day, so one subtract reduces it.
	assign load_val = (new_time >= DAY_MS) ? new_time - DAY_MS : new_time;
	assign inc_val  = (time_q == DAY_MS - 1'b1) ? '0 : time_q + 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_q <= '0;
		end else if (ctl.load) begin
			time_q <= load_val;
		end else if (ctl.inc) begin
			time_q <= inc_val;
		end
	end

	assign time_ms = time_q;

	a_time_in_day: assert property (@(posedge clk) disable iff (!arst_n)
		time_q < DAY_MS)
		else $error("clock left the day range");

	a_load_value: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load |=> time_q == $past(load_val))
		else $error("clock load lost");

endmodule
